// File: rtl/ttm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttm_pkg
// Shared types and constants of the temperature threshold monitor.
// ----------------------------------------------------------------------------
package ttm_pkg;

  localparam int unsigned THRESHOLD_BITS = 16;
  localparam int unsigned RUN_BITS       = 4;
  localparam int unsigned PCT_BITS       = 10;
  localparam int unsigned REASON_BITS    = 2;
  localparam int unsigned CFG_DATA_BITS  = 16;

  localparam logic [RUN_BITS-1:0] RUN_MAX = 4'd15;

  // register indexes
  localparam logic CFG_THRESHOLD    = 1'b0;
  localparam logic CFG_CRITICAL_RUN = 1'b1;

  localparam logic [RUN_BITS-1:0] CRITICAL_RUN_RESET = 4'd3;

  // item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // end reasons
  localparam logic [REASON_BITS-1:0] END_RUNNING  = 2'd0;
  localparam logic [REASON_BITS-1:0] END_REPORT   = 2'd1;
  localparam logic [REASON_BITS-1:0] END_CRITICAL = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_UPDATE   = 6'b000010,
    ST_MEAN_GO  = 6'b000100,
    ST_MEAN_RUN = 6'b001000,
    ST_PCT_RUN  = 6'b010000,
    ST_FINISH   = 6'b100000
  } state_e;

endpackage : ttm_pkg
`default_nettype wire

// File: rtl/ttm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttm_div
// Iterative restoring divider, one quotient bit per cycle. The numerator
// must be below den * 2**QUO_BITS so the quotient fits in QUO_BITS bits.
// ----------------------------------------------------------------------------
module ttm_div #(
  parameter int unsigned DEN_BITS = 16,
  parameter int unsigned QUO_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [DEN_BITS+QUO_BITS-1:0] numer_i,
  input  wire logic [DEN_BITS-1:0]          denom_i,
  output logic                              done_o,
  output logic [QUO_BITS-1:0]               quot_o
);

  localparam int unsigned CNT_BITS = $clog2(QUO_BITS + 1);

  logic                active_q, active_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic [DEN_BITS-1:0] rem_q, rem_d;
  logic [DEN_BITS-1:0] den_q, den_d;
  logic [QUO_BITS-1:0] quo_q, quo_d;

  logic [DEN_BITS:0]   shifted;
  logic [DEN_BITS:0]   diff;
  logic                ge;

  assign shifted = {rem_q, quo_q[QUO_BITS-1]};
  assign ge      = shifted >= {1'b0, den_q};
  assign diff    = shifted - {1'b0, den_q};

  assign done_o = active_q && (cnt_q == '0);
  assign quot_o = quo_q;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    den_d    = den_q;
    quo_d    = quo_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = CNT_BITS'(QUO_BITS);
      rem_d    = numer_i[DEN_BITS+QUO_BITS-1:QUO_BITS];
      quo_d    = numer_i[QUO_BITS-1:0];
      den_d    = denom_i;
    end else if (active_q) begin
      if (cnt_q == '0) begin
        active_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
        rem_d = ge ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
        quo_d = {quo_q[QUO_BITS-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

endmodule : ttm_div
`default_nettype wire

// File: rtl/temperature_threshold_monitor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// temperature_threshold_monitor
// Session statistics and over-limit alerting for signed temperature samples.
// ----------------------------------------------------------------------------
// One item is in flight at a time: an item is taken, the session state is
// updated, then the mean and the over-limit share in tenths of a percent are
// worked out one after the other by a shared restoring divider that yields
// one quotient bit per cycle. The result sits in an output register, so the
// next item is taken while a result waits. A report item returns the totals
// and then clears the session.
module temperature_threshold_monitor #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic                                  cfg_index_i,
  input  wire logic [ttm_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire logic                                  kind_i,
  input  wire logic signed [SAMPLE_BITS-1:0]         temperature_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output logic                                       over_limit_o,
  output logic [ttm_pkg::RUN_BITS-1:0]               run_length_o,
  output logic                                       critical_o,
  output logic                                       ignored_o,
  output logic [COUNT_BITS-1:0]                      total_o,
  output logic signed [SAMPLE_BITS-1:0]              mean_o,
  output logic signed [SAMPLE_BITS-1:0]              highest_o,
  output logic signed [SAMPLE_BITS-1:0]              lowest_o,
  output logic [COUNT_BITS-1:0]                      above_total_o,
  output logic [ttm_pkg::PCT_BITS-1:0]               percent_tenths_o,
  output logic [ttm_pkg::REASON_BITS-1:0]            end_reason_o
);

  localparam int unsigned SW = SAMPLE_BITS + COUNT_BITS;
  localparam int unsigned QW = (SAMPLE_BITS > ttm_pkg::PCT_BITS) ? SAMPLE_BITS
                                                                  : ttm_pkg::PCT_BITS;
  localparam int unsigned NW = COUNT_BITS + QW;
  localparam int unsigned CW = (SAMPLE_BITS > ttm_pkg::THRESHOLD_BITS) ? SAMPLE_BITS
                                                                        : ttm_pkg::THRESHOLD_BITS;

  ttm_pkg::state_e state_q, state_d;

  // configuration
  logic signed [ttm_pkg::THRESHOLD_BITS-1:0] thr_q;
  logic [ttm_pkg::RUN_BITS-1:0]              crit_run_q;

  // session
  logic signed [SW-1:0]          sum_q, sum_d;
  logic [COUNT_BITS-1:0]         count_q, count_d;
  logic [COUNT_BITS-1:0]         above_q, above_d;
  logic signed [SAMPLE_BITS-1:0] max_q, max_d;
  logic signed [SAMPLE_BITS-1:0] min_q, min_d;
  logic [ttm_pkg::RUN_BITS-1:0]  run_q, run_d;
  logic                          stopped_q, stopped_d;

  // item being worked on
  logic                               kind_q;
  logic signed [SAMPLE_BITS-1:0]      temp_q;
  logic                               over_q, over_d;
  logic                               crit_q, crit_d;
  logic                               ign_q, ign_d;
  logic [ttm_pkg::REASON_BITS-1:0]    reason_q, reason_d;
  logic signed [SAMPLE_BITS-1:0]      mean_q, mean_d;
  logic [ttm_pkg::PCT_BITS-1:0]       pct_q, pct_d;

  // output register
  logic                               out_valid_q, out_valid_d;
  logic                               res_over_q, res_crit_q, res_ign_q;
  logic [ttm_pkg::RUN_BITS-1:0]       res_run_q;
  logic [COUNT_BITS-1:0]              res_total_q, res_above_q;
  logic signed [SAMPLE_BITS-1:0]      res_mean_q, res_hi_q, res_lo_q;
  logic [ttm_pkg::PCT_BITS-1:0]       res_pct_q;
  logic [ttm_pkg::REASON_BITS-1:0]    res_reason_q;

  logic                               accept;
  logic                               fin_load;
  logic                               is_over;
  logic                               is_full;
  logic                               is_ign;
  logic [ttm_pkg::RUN_BITS-1:0]       run_next;
  logic                               have_samples;

  logic [SW-1:0]                      sum_mag;
  logic [NW-1:0]                      above_ext;
  logic [NW-1:0]                      mean_num;
  logic [NW-1:0]                      pct_num;
  logic                               div_start;
  logic                               div_sel_pct;
  logic                               div_done;
  logic [QW-1:0]                      div_quot;
  logic [SAMPLE_BITS-1:0]             mean_mag;

  assign accept   = in_valid_i && in_ready_o;
  assign fin_load = (state_q == ttm_pkg::ST_FINISH) && (!out_valid_q || out_ready_i);

  assign is_over  = CW'(temp_q) > CW'(thr_q);
  assign is_full  = count_q == '1;
  assign is_ign   = stopped_q || is_full;
  assign run_next = !is_over ? '0 : (run_q < ttm_pkg::RUN_MAX) ? run_q + 1'b1 : run_q;
  assign have_samples = count_q != '0;

  assign sum_mag   = sum_q[SW-1] ? (~sum_q + 1'b1) : sum_q;
  assign mean_num  = NW'(sum_mag);
  assign above_ext = NW'(above_q);
  assign pct_num   = (above_ext << 10) - (above_ext << 4) - (above_ext << 3);
  assign mean_mag  = SAMPLE_BITS'(div_quot);

  assign div_sel_pct = state_q == ttm_pkg::ST_MEAN_RUN;
  assign div_start   = (state_q == ttm_pkg::ST_MEAN_GO)
                    || ((state_q == ttm_pkg::ST_MEAN_RUN) && div_done);

  ttm_div #(
    .DEN_BITS (COUNT_BITS),
    .QUO_BITS (QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (div_sel_pct ? pct_num : mean_num),
    .denom_i (count_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    count_d     = count_q;
    above_d     = above_q;
    max_d       = max_q;
    min_d       = min_q;
    run_d       = run_q;
    stopped_d   = stopped_q;
    over_d      = over_q;
    crit_d      = crit_q;
    ign_d       = ign_q;
    reason_d    = reason_q;
    mean_d      = mean_q;
    pct_d       = pct_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ttm_pkg::ST_IDLE: begin
        if (accept) state_d = ttm_pkg::ST_UPDATE;
      end
      ttm_pkg::ST_UPDATE: begin
        over_d = 1'b0;
        crit_d = 1'b0;
        ign_d  = 1'b0;
        if (kind_q == ttm_pkg::KIND_REPORT) begin
          reason_d = stopped_q ? ttm_pkg::END_CRITICAL : ttm_pkg::END_REPORT;
        end else if (is_ign) begin
          ign_d    = 1'b1;
          reason_d = stopped_q ? ttm_pkg::END_CRITICAL : ttm_pkg::END_RUNNING;
        end else begin
          if (!have_samples) begin
            max_d = temp_q;
            min_d = temp_q;
          end else begin
            if (temp_q > max_q) max_d = temp_q;
            if (temp_q < min_q) min_d = temp_q;
          end
          count_d = count_q + 1'b1;
          sum_d   = sum_q + SW'(temp_q);
          over_d  = is_over;
          if (is_over) above_d = above_q + 1'b1;
          run_d   = run_next;
          crit_d  = run_next == crit_run_q;
          if (run_next == crit_run_q) stopped_d = 1'b1;
          reason_d = (stopped_q || (run_next == crit_run_q)) ? ttm_pkg::END_CRITICAL
                                                              : ttm_pkg::END_RUNNING;
        end
        state_d = ttm_pkg::ST_MEAN_GO;
      end
      ttm_pkg::ST_MEAN_GO: begin
        state_d = ttm_pkg::ST_MEAN_RUN;
      end
      ttm_pkg::ST_MEAN_RUN: begin
        if (div_done) begin
          mean_d  = sum_q[SW-1] ? (~mean_mag + 1'b1) : mean_mag;
          state_d = ttm_pkg::ST_PCT_RUN;
        end
      end
      ttm_pkg::ST_PCT_RUN: begin
        if (div_done) begin
          pct_d   = div_quot[ttm_pkg::PCT_BITS-1:0];
          state_d = ttm_pkg::ST_FINISH;
        end
      end
      ttm_pkg::ST_FINISH: begin
        if (fin_load) begin
          out_valid_d = 1'b1;
          state_d     = ttm_pkg::ST_IDLE;
          if (kind_q == ttm_pkg::KIND_REPORT) begin
            sum_d     = '0;
            count_d   = '0;
            above_d   = '0;
            run_d     = '0;
            stopped_d = 1'b0;
          end
        end
      end
      default: state_d = ttm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttm_pkg::ST_IDLE;
      thr_q       <= '0;
      crit_run_q  <= ttm_pkg::CRITICAL_RUN_RESET;
      sum_q       <= '0;
      count_q     <= '0;
      above_q     <= '0;
      run_q       <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      above_q     <= above_d;
      run_q       <= run_d;
      stopped_q   <= stopped_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ttm_pkg::CFG_THRESHOLD:    thr_q      <= cfg_data_i;
          ttm_pkg::CFG_CRITICAL_RUN: crit_run_q <= cfg_data_i[ttm_pkg::RUN_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    max_q    <= max_d;
    min_q    <= min_d;
    over_q   <= over_d;
    crit_q   <= crit_d;
    ign_q    <= ign_d;
    reason_q <= reason_d;
    mean_q   <= mean_d;
    pct_q    <= pct_d;
    if (accept) begin
      kind_q <= kind_i;
      temp_q <= temperature_i;
    end
    if (fin_load) begin
      res_over_q   <= over_q;
      res_crit_q   <= crit_q;
      res_ign_q    <= ign_q;
      res_run_q    <= run_q;
      res_total_q  <= count_q;
      res_above_q  <= above_q;
      res_mean_q   <= have_samples ? mean_q : '0;
      res_hi_q     <= have_samples ? max_q : '0;
      res_lo_q     <= have_samples ? min_q : '0;
      res_pct_q    <= have_samples ? pct_q : '0;
      res_reason_q <= reason_q;
    end
  end

  assign in_ready_o       = state_q == ttm_pkg::ST_IDLE;
  assign out_valid_o      = out_valid_q;
  assign over_limit_o     = res_over_q;
  assign run_length_o     = res_run_q;
  assign critical_o       = res_crit_q;
  assign ignored_o        = res_ign_q;
  assign total_o          = res_total_q;
  assign mean_o           = res_mean_q;
  assign highest_o        = res_hi_q;
  assign lowest_o         = res_lo_q;
  assign above_total_o    = res_above_q;
  assign percent_tenths_o = res_pct_q;
  assign end_reason_o     = res_reason_q;

endmodule : temperature_threshold_monitor
`default_nettype wire
